// ===== src/mlpc_pkg.sv =====
// mlpc_pkg: shared types, codes and helpers of the MPLS label push classifier.
// Depends on nothing; used by mlpc_cell, the top level and the testbench.
package mlpc_pkg;

  localparam logic REQ_CLASSIFY = 1'b0;
  localparam logic REQ_WRITE    = 1'b1;

  localparam logic [1:0] TBL_CLIENT   = 2'd0;
  localparam logic [1:0] TBL_PRIORITY = 2'd1;
  localparam logic [1:0] TBL_DEFAULT  = 2'd2;

  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_TX      = 2'd1;
  localparam logic [1:0] ACT_PASS    = 2'd2;
  localparam logic [1:0] ACT_WRITTEN = 2'd3;

  localparam logic [1:0] SRC_FALLBACK = 2'd0;
  localparam logic [1:0] SRC_PRIORITY = 2'd1;
  localparam logic [1:0] SRC_DEFAULT  = 2'd2;

  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam logic [3:0]  IHL_PLAIN      = 4'd5;
  localparam logic [5:0]  PLEN_MAX       = 6'd32;
  localparam logic [19:0] FALLBACK_RESET = 20'd1000000;
  localparam logic [2:0]  MPLS_TC        = 3'd0;
  localparam logic        MPLS_BOS       = 1'b1;

  localparam int unsigned ADDR_W       = 3;
  localparam logic        REG_FALLBACK = 1'b0;

  typedef struct packed {
    logic        vld;
    logic        req_type;
    logic [15:0] ether_type;
    logic [3:0]  ip_ihl;
    logic [7:0]  ip_ttl;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [1:0]  table_sel;
    logic [5:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  prefix_len;
    logic [31:0] prefix_addr;
    logic [19:0] entry_label;
  } mlpc_tok_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  len;
    logic [19:0] label;
  } mlpc_best_t;

  typedef struct packed {
    logic       client_hit;
    mlpc_best_t pri;
    mlpc_best_t dflt;
  } mlpc_acc_t;

  function automatic logic prefix_hit(input logic [31:0] addr, input logic [31:0] pfx,
                                      input logic [5:0] len);
    logic [31:0] mask;
    mask = ~(32'hFFFF_FFFF >> len);
    return ((addr ^ pfx) & mask) == 32'd0;
  endfunction

endpackage

// ===== src/mlpc_if.sv =====
// mlpc_item_if / mlpc_result_if: valid/ready channels carrying one word each.
// Depends on nothing; used by the top level.
interface mlpc_item_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] ether_type;
  logic [3:0]  ip_ihl;
  logic [7:0]  ip_ttl;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [1:0]  table_sel;
  logic [5:0]  entry_index;
  logic        entry_valid;
  logic [5:0]  prefix_len;
  logic [31:0] prefix_addr;
  logic [19:0] entry_label;

  modport source (output valid, req_type, ether_type, ip_ihl, ip_ttl, src_ip, dst_ip,
                  table_sel, entry_index, entry_valid, prefix_len, prefix_addr,
                  entry_label, input ready);
  modport sink (input valid, req_type, ether_type, ip_ihl, ip_ttl, src_ip, dst_ip,
                table_sel, entry_index, entry_valid, prefix_len, prefix_addr,
                entry_label, output ready);
endinterface

interface mlpc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] mpls_entry;
  logic [19:0] chosen_label;
  logic [1:0]  label_source;

  modport source (output valid, action, mpls_entry, chosen_label, label_source,
                  input ready);
  modport sink (input valid, action, mpls_entry, chosen_label, label_source,
                output ready);
endinterface

// ===== src/mlpc_cell.sv =====
// mlpc_cell: one slot of the client, priority and default prefix tables.
// Applies table writes addressed to its slot and folds its slot into the
// running longest-prefix results of passing lookups. Depends on mlpc_pkg.
module mlpc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  mlpc_pkg::mlpc_tok_t tok_in,
  input  mlpc_pkg::mlpc_acc_t acc_in,
  output mlpc_pkg::mlpc_tok_t tok,
  output mlpc_pkg::mlpc_acc_t acc
);
  import mlpc_pkg::*;

  logic        c_vld, p_vld, d_vld;
  logic [5:0]  c_len, p_len, d_len;
  logic [31:0] c_addr, p_addr, d_addr;
  logic [19:0] p_label, d_label;

  logic      wr;
  logic      p_upd, d_upd;
  mlpc_acc_t acc_next;

  assign wr = en && tok_in.vld && (tok_in.req_type == REQ_WRITE)
              && (32'(tok_in.entry_index) == IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      p_vld <= 1'b0;
      d_vld <= 1'b0;
    end else if (wr) begin
      case (tok_in.table_sel)
        TBL_CLIENT:   c_vld <= tok_in.entry_valid;
        TBL_PRIORITY: p_vld <= tok_in.entry_valid;
        TBL_DEFAULT:  d_vld <= tok_in.entry_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      case (tok_in.table_sel)
        TBL_CLIENT: begin
          c_len  <= tok_in.prefix_len;
          c_addr <= tok_in.prefix_addr;
        end
        TBL_PRIORITY: begin
          p_len   <= tok_in.prefix_len;
          p_addr  <= tok_in.prefix_addr;
          p_label <= tok_in.entry_label;
        end
        TBL_DEFAULT: begin
          d_len   <= tok_in.prefix_len;
          d_addr  <= tok_in.prefix_addr;
          d_label <= tok_in.entry_label;
        end
        default: ;
      endcase
    end
  end

  // strictly longer wins, so the lowest slot keeps ties
  assign p_upd = p_vld && prefix_hit(tok_in.dst_ip, p_addr, p_len)
                 && (!acc_in.pri.hit || (p_len > acc_in.pri.len));
  assign d_upd = d_vld && prefix_hit(tok_in.dst_ip, d_addr, d_len)
                 && (!acc_in.dflt.hit || (d_len > acc_in.dflt.len));

  always_comb begin
    acc_next = acc_in;
    if (c_vld && prefix_hit(tok_in.src_ip, c_addr, c_len)) begin
      acc_next.client_hit = 1'b1;
    end
    if (p_upd) begin
      acc_next.pri = '{hit: 1'b1, len: p_len, label: p_label};
    end
    if (d_upd) begin
      acc_next.dflt = '{hit: 1'b1, len: d_len, label: d_label};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
      acc <= '0;
    end else if (en) begin
      tok <= tok_in;
      acc <= acc_next;
    end
  end

endmodule

// ===== src/mpls_label_push_lpm_classifier_unit.sv =====
// mpls_label_push_lpm_classifier_unit: top level, a chain of mlpc_cell slots,
// the label decision, the result register and the APB register.
// Depends on mlpc_pkg, mlpc_item_if, mlpc_result_if and mlpc_cell.
//
//   channel  dir  handshake             word
//   item     in   valid/ready           header or table write
//   result   out  valid/ready           action, mpls_entry, label, source
//   apb      in   psel/penable/pready   fallback_label at byte 0
//
// One word enters per cycle while the result channel is not stalled; it passes
// through the register of every cell in the chain and then the result register.
// Writes and lookups stay in order. A stalled result freezes the whole chain.
// Reset clears every table slot at once.
module mpls_label_push_lpm_classifier_unit #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  mlpc_item_if.sink                   item,
  mlpc_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mlpc_pkg::*;

  localparam int unsigned N = TABLE_ENTRIES;

  mlpc_tok_t tok [0:N];
  mlpc_acc_t acc [0:N];

  logic        adv;
  logic [19:0] fallback_label;
  logic [1:0]  action_next;
  logic [19:0] label_next;
  logic [1:0]  lsrc_next;
  mlpc_tok_t   last;
  mlpc_acc_t   last_acc;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_label <= FALLBACK_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FALLBACK)) begin
      fallback_label <= pwdata[19:0];
    end
  end

  assign prdata = (paddr[2] == REG_FALLBACK) ? {12'd0, fallback_label} : 32'd0;

  // chain entry
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  assign tok[0] = '{
    vld:         item.valid,
    req_type:    item.req_type,
    ether_type:  item.ether_type,
    ip_ihl:      item.ip_ihl,
    ip_ttl:      item.ip_ttl,
    src_ip:      item.src_ip,
    dst_ip:      item.dst_ip,
    table_sel:   item.table_sel,
    entry_index: item.entry_index,
    entry_valid: item.entry_valid,
    prefix_len:  (item.prefix_len > PLEN_MAX) ? PLEN_MAX : item.prefix_len,
    prefix_addr: item.prefix_addr,
    entry_label: item.entry_label
  };
  assign acc[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mlpc_cell #(.IDX(k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .tok_in (tok[k]),
      .acc_in (acc[k]),
      .tok    (tok[k+1]),
      .acc    (acc[k+1])
    );
  end

  // label decision
  assign last     = tok[N];
  assign last_acc = acc[N];

  always_comb begin
    action_next = ACT_TX;
    label_next  = fallback_label;
    lsrc_next   = SRC_FALLBACK;
    if (last.req_type == REQ_WRITE) begin
      action_next = ACT_WRITTEN;
    end else if (last.ether_type != ETH_IPV4) begin
      action_next = ACT_PASS;
    end else if (last.ip_ihl != IHL_PLAIN) begin
      action_next = ACT_DROP;
    end else if (last_acc.client_hit && last_acc.pri.hit) begin
      label_next = last_acc.pri.label;
      lsrc_next  = SRC_PRIORITY;
    end else if (last_acc.dflt.hit) begin
      label_next = last_acc.dflt.label;
      lsrc_next  = SRC_DEFAULT;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.action <= action_next;
      if (action_next == ACT_TX) begin
        result.mpls_entry   <= {label_next, MPLS_TC, MPLS_BOS, last.ip_ttl};
        result.chosen_label <= label_next;
        result.label_source <= lsrc_next;
      end else begin
        result.mpls_entry   <= 32'd0;
        result.chosen_label <= 20'd0;
        result.label_source <= SRC_FALLBACK;
      end
    end
  end

  chain_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(tok[N].vld) && $stable(acc[N]))
    else $error("cell chain moved during a result stall");

  idle_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.action != ACT_TX) |->
      (result.mpls_entry == 32'd0) && (result.chosen_label == 20'd0)
      && (result.label_source == SRC_FALLBACK))
    else $error("non-transmit result carries label fields");

  entry_label: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.action == ACT_TX) |->
      (result.mpls_entry[31:12] == result.chosen_label) && result.mpls_entry[8])
    else $error("mpls entry disagrees with chosen label");

endmodule

// ===== tb/mpls_label_push_lpm_classifier_unit_test.sv =====
// Testbench for mpls_label_push_lpm_classifier_unit: directed and random header and
// prefix-table words, checked against an in-bench label predictor and scoreboard.
// Depends on mlpc_pkg, mlpc_item_if, mlpc_result_if and the unit itself.
`timescale 1ns / 100ps

module mpls_label_push_lpm_classifier_unit_test;
  import mlpc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned CHAIN_LATENCY = TABLE_ENTRIES + 1;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned RANDOM_WORDS  = 1300;
  localparam int unsigned PHASES        = 4;
  localparam logic [1:0]  TBL_UNUSED    = 2'd3;
  localparam logic [ADDR_W-1:0] FALLBACK_ADDR = ADDR_W'(4 * REG_FALLBACK);

  localparam int unsigned DRAIN_OPEN     = 0;
  localparam int unsigned DRAIN_RANDOM   = 1;
  localparam int unsigned DRAIN_PERIODIC = 2;
  localparam int unsigned DRAIN_CHOKED   = 3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] ether_type;
    logic [3:0]  ip_ihl;
    logic [7:0]  ip_ttl;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [1:0]  table_sel;
    logic [5:0]  entry_index;
    logic        entry_valid;
    logic [5:0]  prefix_len;
    logic [31:0] prefix_addr;
    logic [19:0] entry_label;
  } hdr_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] mpls_entry;
    logic [19:0] chosen_label;
    logic [1:0]  label_source;
  } push_result_t;

  typedef struct packed {
    logic        vld;
    logic [5:0]  len;
    logic [31:0] addr;
    logic [19:0] label;
  } lpm_slot_t;

  class label_push_board;
    lpm_slot_t    clients[TABLE_ENTRIES];
    lpm_slot_t    prio_dsts[TABLE_ENTRIES];
    lpm_slot_t    dflt_dsts[TABLE_ENTRIES];
    logic [19:0]  fallback;
    push_result_t pending_results[$];
    int unsigned  errors;
    int unsigned  words_seen;
    int unsigned  action_count[4];
    int unsigned  source_count[3];

    function new();
      foreach (clients[i]) begin
        clients[i]   = '0;
        prio_dsts[i] = '0;
        dflt_dsts[i] = '0;
      end
      fallback = FALLBACK_RESET;
    endfunction

    function void set_fallback(logic [19:0] value);
      fallback = value;
    endfunction

    function logic [31:0] plen_mask(logic [5:0] len);
      return (len == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - int'(len)));
    endfunction

    function bit longest_match(input lpm_slot_t tbl[TABLE_ENTRIES], input logic [31:0] addr,
                               output logic [19:0] label);
      bit         hit;
      logic [5:0] best;
      hit = 1'b0;
      best = '0;
      label = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl[i].vld && (((addr ^ tbl[i].addr) & plen_mask(tbl[i].len)) == 32'd0) &&
            (!hit || tbl[i].len > best)) begin
          hit = 1'b1;
          best = tbl[i].len;
          label = tbl[i].label;
        end
      end
      return hit;
    endfunction

    function void note_word(hdr_word_t w);
      push_result_t r;
      lpm_slot_t    slot;
      logic [19:0]  lbl;
      r = '0;
      words_seen++;
      if (w.req_type == REQ_WRITE) begin
        if (w.table_sel != TBL_UNUSED && w.entry_index < TABLE_ENTRIES) begin
          slot = '0;
          if (w.entry_valid) begin
            slot.vld = 1'b1;
            slot.len = (w.prefix_len > PLEN_MAX) ? PLEN_MAX : w.prefix_len;
            slot.addr = w.prefix_addr;
            slot.label = (w.table_sel == TBL_CLIENT) ? 20'd0 : w.entry_label;
          end
          case (w.table_sel)
            TBL_CLIENT:   clients[w.entry_index] = slot;
            TBL_PRIORITY: prio_dsts[w.entry_index] = slot;
            default:      dflt_dsts[w.entry_index] = slot;
          endcase
        end
        r.action = ACT_WRITTEN;
      end else if (w.ether_type != ETH_IPV4) begin
        r.action = ACT_PASS;
      end else if (w.ip_ihl != IHL_PLAIN) begin
        r.action = ACT_DROP;
      end else begin
        r.action = ACT_TX;
        r.chosen_label = fallback;
        r.label_source = SRC_FALLBACK;
        if (longest_match(clients, w.src_ip, lbl)) begin
          if (longest_match(prio_dsts, w.dst_ip, lbl)) begin
            r.chosen_label = lbl;
            r.label_source = SRC_PRIORITY;
          end else if (longest_match(dflt_dsts, w.dst_ip, lbl)) begin
            r.chosen_label = lbl;
            r.label_source = SRC_DEFAULT;
          end
        end else if (longest_match(dflt_dsts, w.dst_ip, lbl)) begin
          r.chosen_label = lbl;
          r.label_source = SRC_DEFAULT;
        end
        r.mpls_entry = {r.chosen_label, MPLS_TC, MPLS_BOS, w.ip_ttl};
        source_count[r.label_source]++;
      end
      action_count[r.action]++;
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 50)
        $display("MISMATCH %s: got %0h, want %0h (after %0d words)", what, got, want,
                 words_seen);
    endtask

    task check_result(push_result_t got);
      push_result_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing pending, action", 32'(got.action), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.action !== want.action)
        report("action", 32'(got.action), 32'(want.action));
      if (got.mpls_entry !== want.mpls_entry)
        report("mpls_entry", got.mpls_entry, want.mpls_entry);
      if (got.chosen_label !== want.chosen_label)
        report("chosen_label", 32'(got.chosen_label), 32'(want.chosen_label));
      if (got.label_source !== want.label_source)
        report("label_source", 32'(got.label_source), 32'(want.label_source));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  mlpc_item_if   item_ch();
  mlpc_result_if res_ch();

  label_push_board board = new();
  int unsigned     cycle_count;
  int unsigned     burst_left;
  logic [31:0]     addr_bases[8];

  mpls_label_push_lpm_classifier_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        board.note_word({item_ch.req_type, item_ch.ether_type, item_ch.ip_ihl, item_ch.ip_ttl,
                         item_ch.src_ip, item_ch.dst_ip, item_ch.table_sel,
                         item_ch.entry_index, item_ch.entry_valid, item_ch.prefix_len,
                         item_ch.prefix_addr, item_ch.entry_label});
      if (res_ch.valid && res_ch.ready)
        board.check_result({res_ch.action, res_ch.mpls_entry, res_ch.chosen_label,
                            res_ch.label_source});
    end
  end

  // result side back-pressure, with a pattern picked at random for each span
  initial begin : result_drain
    int unsigned mode;
    int unsigned span;
    res_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(DRAIN_OPEN, DRAIN_CHOKED);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          DRAIN_OPEN:     res_ch.ready <= 1'b1;
          DRAIN_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
          DRAIN_PERIODIC: res_ch.ready <= (cycle_count % 3 != 0);
          default:        res_ch.ready <= ($urandom_range(0, 29) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout at cycle %0d with %0d results outstanding", cycle_count,
             board.pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic hdr_word_t noise_word();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic hdr_word_t header_word(logic [15:0] eth, logic [3:0] ihl,
                                            logic [7:0] ttl, logic [31:0] src,
                                            logic [31:0] dst);
    hdr_word_t w;
    w = noise_word();
    w.req_type = REQ_CLASSIFY;
    w.ether_type = eth;
    w.ip_ihl = ihl;
    w.ip_ttl = ttl;
    w.src_ip = src;
    w.dst_ip = dst;
    return w;
  endfunction

  function automatic hdr_word_t table_word(logic [1:0] sel, logic [5:0] idx, logic vld,
                                           logic [5:0] len, logic [31:0] addr,
                                           logic [19:0] lbl);
    hdr_word_t w;
    w = noise_word();
    w.req_type = REQ_WRITE;
    w.table_sel = sel;
    w.entry_index = idx;
    w.entry_valid = vld;
    w.prefix_len = len;
    w.prefix_addr = addr;
    w.entry_label = lbl;
    return w;
  endfunction

  // addresses near a small pool of bases, so prefixes actually hit
  function automatic logic [31:0] pool_addr();
    int unsigned k;
    if ($urandom_range(0, 9) == 0) return $urandom;
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 12);
    return addr_bases[$urandom_range(0, 7)] ^ (k == 0 ? 32'd0 : ($urandom >> (32 - k)));
  endfunction

  function automatic hdr_word_t random_word();
    hdr_word_t   w;
    int unsigned pick;
    w = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      w.req_type = REQ_WRITE;
      case ($urandom_range(0, 15))
        0:             w.table_sel = TBL_UNUSED;
        1, 2, 3, 4, 5: w.table_sel = TBL_CLIENT;
        6, 7, 8, 9:    w.table_sel = TBL_PRIORITY;
        default:       w.table_sel = TBL_DEFAULT;
      endcase
      if ($urandom_range(0, 1) == 0) w.entry_index = 6'($urandom_range(0, 7));
      w.entry_valid = ($urandom_range(0, 6) != 0);
      if ($urandom_range(0, 99) == 0) w.prefix_len = 6'd0;
      else if ($urandom_range(0, 9) != 0) w.prefix_len = 6'($urandom_range(1, 32));
      w.prefix_addr = pool_addr();
    end else begin
      w.req_type = REQ_CLASSIFY;
      w.src_ip = pool_addr();
      w.dst_ip = pool_addr();
      if (pick >= 36) begin
        w.ether_type = ETH_IPV4;
        if (pick >= 43) w.ip_ihl = IHL_PLAIN;
      end
    end
    return w;
  endfunction

  task automatic send_word(input hdr_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid       <= 1'b1;
    item_ch.req_type    <= w.req_type;
    item_ch.ether_type  <= w.ether_type;
    item_ch.ip_ihl      <= w.ip_ihl;
    item_ch.ip_ttl      <= w.ip_ttl;
    item_ch.src_ip      <= w.src_ip;
    item_ch.dst_ip      <= w.dst_ip;
    item_ch.table_sel   <= w.table_sel;
    item_ch.entry_index <= w.entry_index;
    item_ch.entry_valid <= w.entry_valid;
    item_ch.prefix_len  <= w.prefix_len;
    item_ch.prefix_addr <= w.prefix_addr;
    item_ch.entry_label <= w.entry_label;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_fallback(input logic [19:0] value);
    logic [31:0] seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FALLBACK_ADDR;
    pwdata  <= {12'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_fallback(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen[19:0] !== value) board.report("fallback_label readback", seen, 32'(value));
  endtask

  initial begin : stimulus
    logic [19:0] fb;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.req_type    <= REQ_CLASSIFY;
    item_ch.ether_type  <= '0;
    item_ch.ip_ihl      <= '0;
    item_ch.ip_ttl      <= '0;
    item_ch.src_ip      <= '0;
    item_ch.dst_ip      <= '0;
    item_ch.table_sel   <= TBL_CLIENT;
    item_ch.entry_index <= '0;
    item_ch.entry_valid <= 1'b0;
    item_ch.prefix_len  <= '0;
    item_ch.prefix_addr <= '0;
    item_ch.entry_label <= '0;
    foreach (addr_bases[i]) addr_bases[i] = $urandom;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty tables, non-IPv4 and bad header lengths
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd0, 32'd0, 32'd0));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(header_word(16'h86DD, IHL_PLAIN, 8'd64, 32'd1, 32'd2));
    send_word(header_word(16'hFFFF, 4'hF, 8'd64, 32'd1, 32'd2));
    send_word(header_word(16'h0000, IHL_PLAIN, 8'd64, 32'd1, 32'd2));
    send_word(header_word(ETH_IPV4, 4'd0, 8'd64, 32'd1, 32'd2));
    send_word(header_word(ETH_IPV4, 4'hF, 8'd64, 32'd1, 32'd2));
    send_word(header_word(ETH_IPV4, 4'd4, 8'd64, 32'd1, 32'd2));
    // default table only while source misses; saturated length, don't-care bits
    send_word(table_word(TBL_DEFAULT, 6'd0, 1'b1, 6'd8, 32'h0A12_3456, 20'd111));
    send_word(table_word(TBL_DEFAULT, 6'd5, 1'b1, 6'd45, 32'h0A01_0203, 20'hFFFFF));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd17, 32'h0102_0304, 32'h0A01_0203));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd18, 32'h0102_0304, 32'h0A01_0204));
    send_word(table_word(TBL_PRIORITY, 6'd3, 1'b1, 6'd16, 32'h0A01_FFFF, 20'd333));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd19, 32'h0102_0304, 32'h0A01_0000));
    // client match-all entry enables the priority table
    send_word(table_word(TBL_CLIENT, 6'd63, 1'b1, 6'd0, 32'hDEAD_BEEF, 20'hABCDE));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd20, 32'h0102_0304, 32'h0A01_0203));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd21, 32'h0102_0304, 32'h0A02_0000));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd22, 32'h0102_0304, 32'h0B00_0000));
    // equal lengths: lowest slot wins
    send_word(table_word(TBL_PRIORITY, 6'd1, 1'b1, 6'd16, 32'h0A01_1234, 20'd444));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd23, 32'h0102_0304, 32'h0A01_0203));
    send_word(table_word(TBL_UNUSED, 6'd1, 1'b1, 6'd32, 32'h0A01_0203, 20'd555));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd24, 32'h0102_0304, 32'h0A01_0203));
    send_word(table_word(TBL_CLIENT, 6'd63, 1'b0, 6'd0, 32'd0, 20'd0));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd25, 32'h0102_0304, 32'h0A01_0203));
    send_word(table_word(TBL_CLIENT, 6'd0, 1'b1, 6'd32, 32'hC0A8_0001, 20'd7));
    send_word(header_word(ETH_IPV4, IHL_PLAIN, 8'd26, 32'hC0A8_0001, 32'h0B00_0000));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       fb = 20'hFFFFF;
        1:       fb = 20'd0;
        2:       fb = 20'($urandom);
        default: fb = FALLBACK_RESET;
      endcase
      write_fallback(fb);
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        if (n == RANDOM_WORDS / (2 * PHASES)) wait_drained();
        send_word(random_word());
      end
    end

    wait_drained();
    repeat (CHAIN_LATENCY + 8) @(posedge clk);
    $display("covered %0d words: %0d transmitted, %0d passed, %0d dropped, %0d table writes",
             board.words_seen, board.action_count[ACT_TX], board.action_count[ACT_PASS],
             board.action_count[ACT_DROP], board.action_count[ACT_WRITTEN]);
    $display("labels from priority %0d, default %0d, fallback %0d over %0d settings",
             board.source_count[SRC_PRIORITY], board.source_count[SRC_DEFAULT],
             board.source_count[SRC_FALLBACK], PHASES + 1);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
